### src/dtq_pkg.sv
package dtq_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned TimeBitsDefault = 48;
  localparam int unsigned MaxResults = 16;

  localparam int unsigned ReqW = 2;
  localparam int unsigned HandleW = 4;
  localparam int unsigned TagW = 16;
  localparam int unsigned TimeW = 48;

  typedef enum logic [1:0] {
    REQ_SUBMIT_ABS = 2'd0,
    REQ_SUBMIT_REL = 2'd1,
    REQ_CANCEL     = 2'd2,
    REQ_TICK       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_SUBMIT  = 2'd0,
    RES_CANCEL  = 2'd1,
    RES_FIRED   = 2'd2,
    RES_NONE    = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_FIRE_RD,
    ST_OUT
  } state_t;

  // one result travelling from the scan engine to the output register
  typedef struct packed {
    res_t                kind;
    logic [HandleW-1:0]  handle;
    logic [TagW-1:0]     tag;
    logic                ok;
    logic                last;
  } result_t;

endpackage

### src/deadline_timer_queue.sv
// channel | valid     | ready     | payload
// request | req_valid | req_ready | req_type, time_value, handle_in, action_tag_in
// result  | res_valid | res_ready | result_kind, handle_out, action_tag_out, ok, last
// submit and cancel: the result is valid in the cycle after the transaction
// tick: each fired entry takes one scan of the deadline memory, then a tag read and an
// output step; a fired entry is held until the next scan shows whether it is the last;
// the closing empty scan is skipped once the result limit is reached; the single memory
// read port sets this order of steps
// pending bits sit in flip-flops cleared by reset; the deadline and tag memory is not cleared
// a stalled result holds the engine; the next request is taken once the result register is free
module deadline_timer_queue #(
  parameter int unsigned CAPACITY  = dtq_pkg::CapacityDefault,
  parameter int unsigned TIME_BITS = dtq_pkg::TimeBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [dtq_pkg::ReqW-1:0]    req_type,
  input  logic [TIME_BITS-1:0]        time_value,
  input  logic [dtq_pkg::HandleW-1:0] handle_in,
  input  logic [dtq_pkg::TagW-1:0]    action_tag_in,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [1:0]                  result_kind,
  output logic [dtq_pkg::HandleW-1:0] handle_out,
  output logic [dtq_pkg::TagW-1:0]    action_tag_out,
  output logic                        ok,
  output logic                        last
);

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = $clog2(dtq_pkg::MaxResults + 1);
  localparam logic [TIME_BITS-1:0] TMax = '1;

  dtq_pkg::state_t state, state_next;

  logic [CAPACITY-1:0]  pending;
  logic [TIME_BITS-1:0] last_tick;
  logic [TIME_BITS-1:0] now;
  logic [CW-1:0]        scan_idx;
  logic [SW-1:0]        rd_addr;
  logic [SW-1:0]        prev_addr;
  logic                 prev_live;
  logic                 found;
  logic [TIME_BITS-1:0] best_dl;
  logic [SW-1:0]        best_slot;
  logic [NW-1:0]        fired;
  logic                 hold_valid;
  logic [SW-1:0]        hold_slot;
  logic [dtq_pkg::TagW-1:0] hold_tag;
  logic                 res_full;
  dtq_pkg::result_t     res_reg;

  logic                 wr_en;
  logic [SW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_dl;
  logic [TIME_BITS-1:0] rd_dl;
  logic [dtq_pkg::TagW-1:0] rd_tag;

  logic [TIME_BITS-1:0] in_time;
  logic [TIME_BITS:0]   rel_sum;
  logic                 free_any;
  logic [SW-1:0]        free_slot;
  logic                 accept;
  logic                 res_take;
  logic                 cand;

  assign in_time = time_value;
  assign rel_sum = {1'b0, last_tick} + {1'b0, in_time};
  assign accept = req_valid && req_ready;
  assign res_take = res_valid && res_ready;
  assign req_ready = (state == dtq_pkg::ST_IDLE) && !res_full;

  always_comb begin
    free_any = 1'b0;
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!pending[i]) begin
        free_any = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  assign wr_en = accept && !req_type[1] && free_any;
  assign wr_addr = free_slot;
  always_comb begin
    if (req_type[0]) begin
      wr_dl = rel_sum[TIME_BITS] ? TMax : rel_sum[TIME_BITS-1:0];
    end else begin
      wr_dl = in_time;
    end
  end

  assign rd_addr = scan_idx[SW-1:0];

  dtq_store #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_deadline(wr_dl),
    .wr_tag(action_tag_in), .rd_addr(rd_addr), .rd_deadline(rd_dl), .rd_tag(rd_tag)
  );

  // candidate from last cycle's read
  assign cand = prev_live && pending[prev_addr] && (rd_dl <= now) &&
                (!found || rd_dl < best_dl);

  always_comb begin
    state_next = state;
    case (state)
      dtq_pkg::ST_IDLE: begin
        if (accept && req_type == dtq_pkg::REQ_TICK) state_next = dtq_pkg::ST_SCAN;
      end
      dtq_pkg::ST_SCAN: begin
        if (!prev_live && scan_idx == CW'(CAPACITY)) begin
          state_next = found ? dtq_pkg::ST_FIRE_RD : dtq_pkg::ST_OUT;
        end
      end
      dtq_pkg::ST_FIRE_RD: state_next = dtq_pkg::ST_OUT;
      dtq_pkg::ST_OUT: begin
        if (!res_full) begin
          if (found) begin
            // at the result limit the held entry closes the run without another scan
            state_next = (fired == NW'(dtq_pkg::MaxResults - 1)) ? dtq_pkg::ST_OUT
                                                                  : dtq_pkg::ST_SCAN;
          end else begin
            state_next = dtq_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = dtq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtq_pkg::ST_IDLE;
      pending <= '0;
      last_tick <= '0;
      res_full <= 1'b0;
      scan_idx <= '0;
      prev_live <= 1'b0;
      found <= 1'b0;
      fired <= '0;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_take) res_full <= 1'b0;
      case (state)
        dtq_pkg::ST_IDLE: begin
          if (accept) begin
            case (dtq_pkg::req_t'(req_type))
              dtq_pkg::REQ_SUBMIT_ABS, dtq_pkg::REQ_SUBMIT_REL: begin
                if (free_any) pending[free_slot] <= 1'b1;
                res_reg <= '{dtq_pkg::RES_SUBMIT,
                             free_any ? dtq_pkg::HandleW'(free_slot) : '0,
                             '0, free_any, 1'b1};
                res_full <= 1'b1;
              end
              dtq_pkg::REQ_CANCEL: begin
                res_reg <= '{dtq_pkg::RES_CANCEL, handle_in, '0,
                             (32'(handle_in) < CAPACITY) && pending[SW'(handle_in)],
                             1'b1};
                if (32'(handle_in) < CAPACITY) pending[SW'(handle_in)] <= 1'b0;
                res_full <= 1'b1;
              end
              default: begin
                last_tick <= in_time;
                now <= in_time;
                fired <= '0;
                scan_idx <= '0;
                prev_live <= 1'b0;
                found <= 1'b0;
                hold_valid <= 1'b0;
              end
            endcase
          end
        end
        dtq_pkg::ST_SCAN: begin
          prev_live <= scan_idx < CW'(CAPACITY);
          prev_addr <= rd_addr;
          if (scan_idx < CW'(CAPACITY)) scan_idx <= scan_idx + 1'b1;
          if (cand) begin
            found <= 1'b1;
            best_dl <= rd_dl;
            best_slot <= prev_addr;
          end
          if (state_next == dtq_pkg::ST_FIRE_RD) scan_idx <= CW'(best_slot);
        end
        dtq_pkg::ST_FIRE_RD: ;
        dtq_pkg::ST_OUT: begin
          if (!res_full) begin
            if (found) begin
              // another entry follows, so the held one is not the last
              if (hold_valid) begin
                res_reg <= '{dtq_pkg::RES_FIRED, dtq_pkg::HandleW'(hold_slot), hold_tag,
                             1'b0, 1'b0};
                res_full <= 1'b1;
              end
              pending[best_slot] <= 1'b0;
              hold_valid <= 1'b1;
              hold_slot <= best_slot;
              hold_tag <= rd_tag;
              fired <= fired + 1'b1;
            end else begin
              // empty scan or result limit: close the run or report nothing due
              res_reg <= '{hold_valid ? dtq_pkg::RES_FIRED : dtq_pkg::RES_NONE,
                           hold_valid ? dtq_pkg::HandleW'(hold_slot) : '0,
                           hold_valid ? hold_tag : '0, 1'b0, 1'b1};
              res_full <= 1'b1;
              hold_valid <= 1'b0;
            end
            scan_idx <= '0;
            prev_live <= 1'b0;
            found <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // the tag read is held while the result waits: rd_addr stays on best_slot
  assign res_valid = res_full;
  assign result_kind = res_reg.kind;
  assign handle_out = res_reg.handle;
  assign action_tag_out = res_reg.tag;
  assign ok = res_reg.ok;
  assign last = res_reg.last;

endmodule

### src/dtq_store.sv
module dtq_store #(
  parameter int unsigned CAPACITY  = dtq_pkg::CapacityDefault,
  parameter int unsigned TIME_BITS = dtq_pkg::TimeBitsDefault,
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [SW-1:0]         wr_addr,
  input  logic [TIME_BITS-1:0]  wr_deadline,
  input  logic [dtq_pkg::TagW-1:0] wr_tag,
  input  logic [SW-1:0]         rd_addr,
  output logic [TIME_BITS-1:0]  rd_deadline,
  output logic [dtq_pkg::TagW-1:0] rd_tag
);

  logic [TIME_BITS-1:0]     deadline_mem [CAPACITY];
  logic [dtq_pkg::TagW-1:0] tag_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_mem[wr_addr] <= wr_deadline;
      tag_mem[wr_addr] <= wr_tag;
    end
    rd_deadline <= deadline_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
  end

endmodule
